[rtl/bcd_pkg.sv]
// bcd_pkg: shared types and constants for the BC1..BC5 block decoder.
// No dependencies; imported by every rtl module of the decoder.
package bcd_pkg;

    localparam int TEXELS = 16;
    localparam int IDX_W  = 4;
    localparam int ADDR_W = 3;

    // register index decoded from paddr[2]
    localparam logic REG_IDX_FORMAT_MODE = 1'b0;

    typedef enum logic [2:0] {
        MODE_BC1 = 3'd0,
        MODE_BC2 = 3'd1,
        MODE_BC3 = 3'd2,
        MODE_BC4 = 3'd3,
        MODE_BC5 = 3'd4
    } bcd_mode_t;

    typedef struct packed {
        logic [63:0] first_half;
        logic [63:0] second_half;
    } bcd_blk_t;

    typedef struct packed {
        logic [31:0]      texel;
        logic [IDX_W-1:0] texel_index;
        logic             last_texel;
    } bcd_tex_t;

    // weight widths: red/blue over 186, green over 378, alpha over 35
    localparam int RB_W_W = 8;
    localparam int G_W_W  = 9;
    localparam int A_W_W  = 14;
    localparam int A_UNIT = 35;

    // round(w*255/186): floor((510w + 186) / 372)
    localparam int RB_SCALE = 510;
    localparam int RB_BIAS  = 186;
    localparam int RB_D     = 372;
    localparam int RB_N_W   = 17;
    localparam int RB_S     = 26;
    localparam int RB_M_W   = 18;
    localparam int RB_P_W   = RB_N_W + RB_M_W;
    localparam logic [RB_M_W-1:0] RB_M = RB_M_W'((2**RB_S + RB_D - 1) / RB_D);

    // round(w*255/378): floor((510w + 378) / 756)
    localparam int G_SCALE = 510;
    localparam int G_BIAS  = 378;
    localparam int G_D     = 756;
    localparam int G_N_W   = 18;
    localparam int G_S     = 28;
    localparam int G_M_W   = 19;
    localparam int G_P_W   = G_N_W + G_M_W;
    localparam logic [G_M_W-1:0] G_M = G_M_W'((2**G_S + G_D - 1) / G_D);

    // round(w/35): floor((2w + 35) / 70)
    localparam int A_SCALE = 2;
    localparam int A_BIAS  = A_UNIT;
    localparam int A_D     = 2 * A_UNIT;
    localparam int A_N_W   = 15;
    localparam int A_S     = 22;
    localparam int A_M_W   = 16;
    localparam int A_P_W   = A_N_W + A_M_W;
    localparam logic [A_M_W-1:0] A_M = A_M_W'((2**A_S + A_D - 1) / A_D);

    typedef struct packed {
        bcd_mode_t        mode;
        logic [IDX_W-1:0] k;
        logic             transp;
        logic [3:0]       nib;
    } bcd_meta_t;

    typedef struct packed {
        bcd_meta_t         meta;
        logic [RB_W_W-1:0] w_r;
        logic [G_W_W-1:0]  w_g;
        logic [RB_W_W-1:0] w_b;
        logic [A_W_W-1:0]  w_a0;
        logic [A_W_W-1:0]  w_a1;
    } bcd_wgt_t;

    typedef struct packed {
        bcd_meta_t  meta;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a0;
        logic [7:0] a1;
    } bcd_chan_t;

endpackage

[rtl/bc_texture_block_decoder.sv]
// bc_texture_block_decoder: top level of the BC1..BC5 block decoder with
// the format register. Uses bcd_pkg, bcd_issue, bcd_scale, bcd_pack.
//
//  channel   direction  handshake                   payload
//  blk       in         blk_valid / blk_ready       blk_word  (bcd_blk_t, one block)
//  tx        out        tx_valid / tx_ready         tx_word   (bcd_tex_t, one texel)
//  apb       in/out     psel, penable, pready       paddr, pwdata, prdata
//
// One block word yields 16 texel words, one per cycle while tx does not stall; a new
// block is taken only as the last texel of the current one issues, so the texel issue counter sets the block rate.
// From block accept to the first texel word the data passes the block register,
// then the weight, numerator, product and output registers.
// Reset clears the valid bits, the issue counter and format_mode (BC1).
// A stall on tx holds the output word and backs up the stages without loss.
module bc_texture_block_decoder
    import bcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              blk_valid,
    output logic              blk_ready,
    input  bcd_blk_t          blk_word,
    output logic              tx_valid,
    input  logic              tx_ready,
    output bcd_tex_t          tx_word
);

    bcd_mode_t format_mode_reg;
    bcd_mode_t format_mode_next;

    logic      wgt_valid;
    logic      wgt_ready;
    bcd_wgt_t  wgt;
    logic      chan_valid;
    logic      chan_ready;
    bcd_chan_t chan;
    logic      reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_IDX_FORMAT_MODE);
    assign prdata  = reg_hit ? 32'(format_mode_reg) : 32'h0;

    always_comb
    begin
        format_mode_next = format_mode_reg;
        if (psel && penable && pwrite && pready && reg_hit)
            format_mode_next = bcd_mode_t'(pwdata[2:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            format_mode_reg <= MODE_BC1;
        else
            format_mode_reg <= format_mode_next;
    end

    bcd_issue u_issue (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (format_mode_reg),
        .blk_valid (blk_valid),
        .blk_ready (blk_ready),
        .blk_word  (blk_word),
        .wgt_valid (wgt_valid),
        .wgt_ready (wgt_ready),
        .wgt       (wgt)
    );

    bcd_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .wgt_valid  (wgt_valid),
        .wgt_ready  (wgt_ready),
        .wgt        (wgt),
        .chan_valid (chan_valid),
        .chan_ready (chan_ready),
        .chan       (chan)
    );

    bcd_pack u_pack (
        .clk        (clk),
        .rst_n      (rst_n),
        .chan_valid (chan_valid),
        .chan_ready (chan_ready),
        .chan       (chan),
        .tx_valid   (tx_valid),
        .tx_ready   (tx_ready),
        .tx_word    (tx_word)
    );

endmodule

[rtl/bcd_issue.sv]
// bcd_issue: holds one compressed block and issues its texels in order,
// selecting palette weights per texel into the first pipeline stage. Uses bcd_pkg.
module bcd_issue
    import bcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  bcd_mode_t mode,
    input  logic      blk_valid,
    output logic      blk_ready,
    input  bcd_blk_t  blk_word,
    output logic      wgt_valid,
    input  logic      wgt_ready,
    output bcd_wgt_t  wgt
);

    localparam logic [A_W_W-1:0] W_A_MAX = A_W_W'(A_UNIT * 255);

    function automatic logic [G_W_W-1:0] clr_w(
        input logic [1:0] ci,
        input logic       four,
        input logic [5:0] e0,
        input logic [5:0] e1
    );
        logic [G_W_W-1:0] x0;
        logic [G_W_W-1:0] x1;
        logic [G_W_W-1:0] w;
        x0 = G_W_W'(e0);
        x1 = G_W_W'(e1);
        unique case (ci)
            2'd0:    w = G_W_W'(6) * x0;
            2'd1:    w = G_W_W'(6) * x1;
            2'd2:    w = four ? G_W_W'(2) * (G_W_W'(2) * x0 + x1)
                              : G_W_W'(3) * (x0 + x1);
            default: w = four ? G_W_W'(2) * (x0 + G_W_W'(2) * x1) : '0;
        endcase
        return w;
    endfunction

    function automatic logic [A_W_W-1:0] alp_w(
        input logic [2:0] ai,
        input logic [7:0] a0,
        input logic [7:0] a1
    );
        logic [A_W_W-1:0] x0;
        logic [A_W_W-1:0] x1;
        logic [A_W_W-1:0] i;
        logic [A_W_W-1:0] w;
        x0 = A_W_W'(a0);
        x1 = A_W_W'(a1);
        i  = A_W_W'(ai);
        priority if (ai == 3'd0)
            w = A_W_W'(A_UNIT) * x0;
        else if (ai == 3'd1)
            w = A_W_W'(A_UNIT) * x1;
        else if (a0 > a1)
            w = A_W_W'(5) * ((A_W_W'(8) - i) * x0 + (i - A_W_W'(1)) * x1);
        else if (ai == 3'd6)
            w = '0;
        else if (ai == 3'd7)
            w = W_A_MAX;
        else
            w = A_W_W'(7) * ((A_W_W'(6) - i) * x0 + (i - A_W_W'(1)) * x1);
        return w;
    endfunction

    logic             blk_v_reg;
    logic             blk_v_next;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] k_next;
    bcd_blk_t         blk_reg;
    bcd_mode_t        bmode_reg;
    logic             s1_v_reg;
    logic             s1_v_next;
    bcd_wgt_t         s1_reg;
    bcd_wgt_t         s1_next;

    logic        en1;
    logic        issue;
    logic        last;
    logic        accept;
    logic [63:0] cblk;
    logic [15:0] c0;
    logic [15:0] c1;
    logic [31:0] cidx;
    logic [1:0]  ci;
    logic        four;
    logic [47:0] aw0;
    logic [47:0] aw1;
    logic [5:0]  aoff;

    assign en1       = !s1_v_reg || wgt_ready;
    assign issue     = blk_v_reg && en1;
    assign last      = (k_reg == IDX_W'(TEXELS - 1));
    assign blk_ready = !blk_v_reg || (issue && last);
    assign accept    = blk_valid && blk_ready;
    assign wgt_valid = s1_v_reg;
    assign wgt       = s1_reg;

    always_comb
    begin
        blk_v_next = blk_v_reg;
        k_next     = k_reg;
        if (accept)
        begin
            blk_v_next = 1'b1;
            k_next     = '0;
        end
        else if (issue)
        begin
            blk_v_next = !last;
            k_next     = k_reg + IDX_W'(1);
        end
        s1_v_next = en1 ? issue : s1_v_reg;
    end

    always_comb
    begin
        cblk = (bmode_reg == MODE_BC1) ? blk_reg.first_half : blk_reg.second_half;
        c0   = cblk[15:0];
        c1   = cblk[31:16];
        cidx = cblk[63:32];
        four = c0 > c1;
        ci   = cidx[{k_reg, 1'b0} +: 2];
        aw0  = blk_reg.first_half[63:16];
        aw1  = blk_reg.second_half[63:16];
        aoff = 6'({k_reg, 1'b0}) + 6'(k_reg);

        s1_next.meta.mode   = bmode_reg;
        s1_next.meta.k      = k_reg;
        s1_next.meta.transp = (ci == 2'd3) && !four;
        s1_next.meta.nib    = blk_reg.first_half[{k_reg, 2'b00} +: 4];
        s1_next.w_r  = RB_W_W'(clr_w(ci, four, {1'b0, c0[15:11]}, {1'b0, c1[15:11]}));
        s1_next.w_g  = clr_w(ci, four, c0[10:5], c1[10:5]);
        s1_next.w_b  = RB_W_W'(clr_w(ci, four, {1'b0, c0[4:0]}, {1'b0, c1[4:0]}));
        s1_next.w_a0 = alp_w(aw0[aoff +: 3], blk_reg.first_half[7:0],
                             blk_reg.first_half[15:8]);
        s1_next.w_a1 = alp_w(aw1[aoff +: 3], blk_reg.second_half[7:0],
                             blk_reg.second_half[15:8]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_v_reg <= 1'b0;
            k_reg     <= '0;
            s1_v_reg  <= 1'b0;
        end
        else
        begin
            blk_v_reg <= blk_v_next;
            k_reg     <= k_next;
            s1_v_reg  <= s1_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            blk_reg   <= blk_word;
            bmode_reg <= mode;
        end
        if (issue)
            s1_reg <= s1_next;
    end

endmodule

[rtl/bcd_scale.sv]
// bcd_scale: two-stage rounding divide of the palette weights to 8-bit
// channels by reciprocal multiplication. Uses bcd_pkg.
module bcd_scale
    import bcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wgt_valid,
    output logic      wgt_ready,
    input  bcd_wgt_t  wgt,
    output logic      chan_valid,
    input  logic      chan_ready,
    output bcd_chan_t chan
);

    logic              s2_v_reg;
    logic              s2_v_next;
    bcd_meta_t         m2_reg;
    logic [RB_N_W-1:0] n_r_reg;
    logic [G_N_W-1:0]  n_g_reg;
    logic [RB_N_W-1:0] n_b_reg;
    logic [A_N_W-1:0]  n_a0_reg;
    logic [A_N_W-1:0]  n_a1_reg;

    logic              s3_v_reg;
    logic              s3_v_next;
    bcd_meta_t         m3_reg;
    logic [RB_P_W-1:0] p_r_reg;
    logic [G_P_W-1:0]  p_g_reg;
    logic [RB_P_W-1:0] p_b_reg;
    logic [A_P_W-1:0]  p_a0_reg;
    logic [A_P_W-1:0]  p_a1_reg;

    logic en2;
    logic en3;
    logic load2;
    logic load3;

    assign en3       = !s3_v_reg || chan_ready;
    assign en2       = !s2_v_reg || en3;
    assign wgt_ready = en2;
    assign load2     = en2 && wgt_valid;
    assign load3     = en3 && s2_v_reg;
    assign s2_v_next = en2 ? wgt_valid : s2_v_reg;
    assign s3_v_next = en3 ? s2_v_reg : s3_v_reg;

    assign chan_valid = s3_v_reg;
    assign chan.meta  = m3_reg;
    assign chan.r     = p_r_reg[RB_S +: 8];
    assign chan.g     = p_g_reg[G_S +: 8];
    assign chan.b     = p_b_reg[RB_S +: 8];
    assign chan.a0    = p_a0_reg[A_S +: 8];
    assign chan.a1    = p_a1_reg[A_S +: 8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s2_v_reg <= s2_v_next;
            s3_v_reg <= s3_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            m2_reg   <= wgt.meta;
            n_r_reg  <= RB_N_W'(wgt.w_r) * RB_N_W'(RB_SCALE) + RB_N_W'(RB_BIAS);
            n_g_reg  <= G_N_W'(wgt.w_g) * G_N_W'(G_SCALE) + G_N_W'(G_BIAS);
            n_b_reg  <= RB_N_W'(wgt.w_b) * RB_N_W'(RB_SCALE) + RB_N_W'(RB_BIAS);
            n_a0_reg <= A_N_W'(wgt.w_a0) * A_N_W'(A_SCALE) + A_N_W'(A_BIAS);
            n_a1_reg <= A_N_W'(wgt.w_a1) * A_N_W'(A_SCALE) + A_N_W'(A_BIAS);
        end
        if (load3)
        begin
            m3_reg   <= m2_reg;
            p_r_reg  <= RB_P_W'(n_r_reg) * RB_P_W'(RB_M);
            p_g_reg  <= G_P_W'(n_g_reg) * G_P_W'(G_M);
            p_b_reg  <= RB_P_W'(n_b_reg) * RB_P_W'(RB_M);
            p_a0_reg <= A_P_W'(n_a0_reg) * A_P_W'(A_M);
            p_a1_reg <= A_P_W'(n_a1_reg) * A_P_W'(A_M);
        end
    end

endmodule

[rtl/bcd_pack.sv]
// bcd_pack: assembles the output texel word per format and holds it in
// the output register. Uses bcd_pkg.
module bcd_pack
    import bcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      chan_valid,
    output logic      chan_ready,
    input  bcd_chan_t chan,
    output logic      tx_valid,
    input  logic      tx_ready,
    output bcd_tex_t  tx_word
);

    logic     out_v_reg;
    logic     out_v_next;
    bcd_tex_t out_reg;
    bcd_tex_t out_next;

    logic        en;
    logic [23:0] rgb;

    assign en         = !out_v_reg || tx_ready;
    assign chan_ready = en;
    assign out_v_next = en ? chan_valid : out_v_reg;
    assign tx_valid   = out_v_reg;
    assign tx_word    = out_reg;

    always_comb
    begin
        rgb = chan.meta.transp ? 24'h0 : {chan.r, chan.g, chan.b};
        unique case (chan.meta.mode)
            MODE_BC1: out_next.texel = {chan.meta.transp ? 8'h00 : 8'hFF, rgb};
            MODE_BC2: out_next.texel = {chan.meta.nib, 4'h0, rgb};
            MODE_BC3: out_next.texel = {chan.a0, rgb};
            MODE_BC4: out_next.texel = {24'h0, chan.a0};
            MODE_BC5: out_next.texel = {8'h00, chan.a0, chan.a1, 8'h00};
            default:  out_next.texel = 32'h0;
        endcase
        out_next.texel_index = chan.meta.k;
        out_next.last_texel  = (chan.meta.k == IDX_W'(TEXELS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else
            out_v_reg <= out_v_next;
    end

    always_ff @(posedge clk)
    begin
        if (en && chan_valid)
            out_reg <= out_next;
    end

endmodule

[rtl/bcd_checker.sv]
// bcd_checker: port-level assertions for bc_texture_block_decoder and the
// bind that attaches them. Uses bcd_pkg.
module bcd_checker
    import bcd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic [31:0]       pwdata,
    input logic [31:0]       prdata,
    input logic              blk_valid,
    input logic              blk_ready,
    input logic              tx_valid,
    input logic              tx_ready,
    input bcd_tex_t          tx_word
);

    // stalled output word holds
    a_tx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && !tx_ready |=> tx_valid && $stable(tx_word))
        else $error("tx word changed while stalled");

    // texels of a block come out in order
    a_tx_order: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && tx_ready && !tx_word.last_texel |=>
            !tx_valid || (tx_word.texel_index == $past(tx_word.texel_index) + IDX_W'(1)))
        else $error("texel index out of order");

    // a fresh block is never followed by another accept in the next cycle
    a_blk_gap: assert property (@(posedge clk) disable iff (!rst_n)
        blk_valid && blk_ready |=> !blk_ready)
        else $error("block accepted back to back");

    // format register reads back what was written
    a_cfg_rb: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr[2] == REG_IDX_FORMAT_MODE)
            ##1 (paddr[2] == REG_IDX_FORMAT_MODE) |->
            prdata[2:0] == $past(pwdata[2:0]))
        else $error("format_mode readback mismatch");

endmodule

bind bc_texture_block_decoder bcd_checker u_bcd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .tx_valid  (tx_valid),
    .tx_ready  (tx_ready),
    .tx_word   (tx_word)
);
